>>> hdl/pal_pkg.sv
// pal_pkg: shared types and constants for the positional array list
// operation codes, result status codes, cell command type
// no dependencies
package pal_pkg;

  localparam int DEFAULT_CAPACITY = 32;
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;

  // operation codes carried by the operation field
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_FIND   = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  // what every cell of the chain does this cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_FIND,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [VALUE_W-1:0]   data;
  } cell_cmd_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ctl_state_t;

endpackage

>>> hdl/positional_array_list_top.sv
// positional_array_list_top: ordered list of signed 32-bit values in a chain of cells
// controller, result register and the cell chain
// depends on pal_pkg and pal_cell
//
// The list lives in a row of CAPACITY cells, entry n in cell n-1, plus an entry count.
// Clear, append, insert and delete finish at the edge that accepts them: every cell takes
// its neighbor's entry at that same edge, so the list is updated and the result registered
// as the transaction is accepted. Find ends at the first match, or at the end of the list
// when there is none, and at acceptance on an empty list: all cells compare at once, then
// the match flags move one cell per cycle toward cell zero while the result side does not
// stall, and the controller looks for the first hit there. One transaction is worked on at
// a time; a new one is taken only when the output register is empty or its result leaves
// at the same edge, and a stalled result side also holds a find scan where it is. Entries
// are not cleared after reset; the count is, so no entry is read before it is written.
module positional_array_list_top #(
  parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pal_pkg::OP_W-1:0]           operation,
  input  logic signed [pal_pkg::VALUE_W-1:0] value,
  input  logic [pal_pkg::POS_W-1:0]          position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pal_pkg::STAT_W-1:0]         status,
  output logic                               found,
  output logic [pal_pkg::POS_W-1:0]          found_position,
  output logic [pal_pkg::POS_W-1:0]          count
);
  import pal_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

  ctl_state_t        state, state_next;
  logic [CW-1:0]     count_q, count_next;
  logic [IW-1:0]     step, step_next;
  cell_cmd_t         cmd;
  logic [IW-1:0]     slot;
  logic              load_out;
  status_t           res_status;
  logic              res_found;
  logic [CW-1:0]     res_fpos;
  logic              accept;
  logic              out_free;
  logic              list_full;
  logic [WW-1:0]     pos_w;
  logic [WW-1:0]     cnt_w;

  logic [VALUE_W-1:0] entry_w [CAPACITY];
  logic               match_w [CAPACITY];

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign list_full = (count_q == CW'(CAPACITY));
  assign pos_w     = WW'(position);
  assign cnt_w     = WW'(count_q);

  // controller: decode the operation, drive the chain, sequence the find scan
  always_comb begin
    state_next = state;
    count_next = count_q;
    step_next  = step;
    cmd.op     = CELL_HOLD;
    cmd.data   = value;
    slot       = '0;
    load_out   = 1'b0;
    res_status = STAT_OK;
    res_found  = 1'b0;
    res_fpos   = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_CLEAR: begin
              count_next = '0;
              load_out   = 1'b1;
            end
            OP_APPEND: begin
              load_out = 1'b1;
              if (list_full) begin
                res_status = STAT_FULL;
              end else begin
                cmd.op     = CELL_INSERT;
                slot       = IW'(count_q);
                count_next = count_q + CW'(1);
              end
            end
            OP_INSERT: begin
              load_out = 1'b1;
              if (list_full) begin
                res_status = STAT_FULL;
              end else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
                res_status = STAT_BADPOS;
              end else begin
                cmd.op     = CELL_INSERT;
                slot       = IW'(pos_w - WW'(1));
                count_next = count_q + CW'(1);
              end
            end
            OP_DELETE: begin
              load_out = 1'b1;
              if (count_q == '0) begin
                res_status = STAT_EMPTY;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                res_status = STAT_BADPOS;
              end else begin
                cmd.op     = CELL_DELETE;
                slot       = IW'(pos_w - WW'(1));
                count_next = count_q - CW'(1);
              end
            end
            OP_FIND: begin
              cmd.op = CELL_FIND;
              if (count_q == '0) begin
                load_out = 1'b1;
              end else begin
                state_next = S_SCAN;
                step_next  = '0;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (match_w[0]) begin
            load_out   = 1'b1;
            res_found  = 1'b1;
            res_fpos   = CW'(step) + CW'(1);
            state_next = S_IDLE;
          end else if (CW'(step) + CW'(1) == count_q) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.op    = CELL_SCAN;
            step_next = step + IW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count_q <= '0;
      step    <= '0;
    end else begin
      state   <= state_next;
      count_q <= count_next;
      step    <= step_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= res_status;
      found          <= res_found;
      found_position <= POS_W'(res_fpos);
      count          <= POS_W'(count_next);
    end
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] lower_e;
    logic [VALUE_W-1:0] upper_e;
    logic               upper_m;

    if (i == 0) begin : g_first
      assign lower_e = cmd.data;
    end else begin : g_lower
      assign lower_e = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_e = '0;
      assign upper_m = 1'b0;
    end else begin : g_upper
      assign upper_e = entry_w[i+1];
      assign upper_m = match_w[i+1];
    end

    pal_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .slot        (slot),
      .limit       (count_q),
      .lower_entry (lower_e),
      .upper_entry (upper_e),
      .upper_match (upper_m),
      .entry       (entry_w[i]),
      .match       (match_w[i])
    );
  end

`ifndef SYNTHESIS
  // count never runs past the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // no new transaction while a find is scanning
  a_scan_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> in_stall)
    else $error("input taken during find scan");

  // scan step stays inside the list
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(step) < count_q))
    else $error("find scan past the end of the list");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result register overwritten");

  // find on a nonempty list enters the scan and leaves the count alone
  a_find_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_FIND && count_q != '0)
      |=> (state == S_SCAN && $stable(count_q)))
    else $error("find did not start its scan");
`endif

endmodule

>>> hdl/pal_cell.sv
// pal_cell: one entry of the list chain with its match flag
// shifts entries up or down with its neighbors, compares for find
// depends on pal_pkg
module pal_cell #(
  parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY,
  parameter int INDEX    = 0
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pal_pkg::cell_cmd_t                      cmd,
  input  logic [$clog2(CAPACITY)-1:0]             slot,
  input  logic [$clog2(CAPACITY+1)-1:0]           limit,
  input  logic [pal_pkg::VALUE_W-1:0]             lower_entry,
  input  logic [pal_pkg::VALUE_W-1:0]             upper_entry,
  input  logic                                    upper_match,
  output logic [pal_pkg::VALUE_W-1:0]             entry,
  output logic                                    match
);
  import pal_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] MY_SLOT  = IW'(INDEX);
  localparam logic [CW-1:0] MY_COUNT = CW'(INDEX);

  // entry storage: insert opens a gap, delete closes one
  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_SLOT > slot) begin
          entry <= lower_entry;
        end else if (MY_SLOT == slot) begin
          entry <= cmd.data;
        end
      end
      CELL_DELETE: begin
        if (MY_SLOT >= slot) begin
          entry <= upper_entry;
        end
      end
      default: begin
      end
    endcase
  end

  // match flag: loaded on find, then moves down toward cell zero
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      case (cmd.op)
        CELL_FIND: match <= (entry == cmd.data) && (MY_COUNT < limit);
        CELL_SCAN: match <= upper_match;
        default:   match <= match;
      endcase
    end
  end

endmodule

>>> tb/positional_array_list_top_tb.sv
// positional_array_list_top_tb: self-checking bench for the positional array list
// drives list operations through valid/stall, predicts each result, checks in order
// depends on pal_pkg and positional_array_list_top
`timescale 1ns / 1ps

module positional_array_list_top_tb;
  import pal_pkg::*;

  localparam int LIST_CAP      = DEFAULT_CAPACITY;
  localparam int STUCK_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 200;
  localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  typedef struct {
    status_t            status;
    logic               found;
    logic [POS_W-1:0]   found_pos;
    logic [POS_W-1:0]   count;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           operation = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic [POS_W-1:0]          position = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STAT_W-1:0]         status;
  logic                      found;
  logic [POS_W-1:0]          found_position;
  logic [POS_W-1:0]          count;

  // list contents as the block should hold them, and results still owed
  logic signed [VALUE_W-1:0] list_model[$];
  list_result_t              pending_results[$];

  int   error_count  = 0;
  int   stuck_cycles = 0;
  bit   idle_enable  = 1'b1;
  bit   hold_request = 1'b0;

  positional_array_list_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .value          (value),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found          (found),
    .found_position (found_position),
    .count          (count)
  );

  always #4 clk = ~clk;

  // apply one operation to the list model and return the result it should give
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic signed [VALUE_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int n;
    int i;
    r.status    = STAT_OK;
    r.found     = 1'b0;
    r.found_pos = '0;
    n = list_model.size();
    case (op)
      OP_CLEAR: begin
        list_model.delete();
      end
      OP_APPEND: begin
        if (n >= LIST_CAP) r.status = STAT_FULL;
        else list_model.push_back(val);
      end
      OP_INSERT: begin
        if (n >= LIST_CAP) r.status = STAT_FULL;
        else if (pos == 0 || int'(pos) > n + 1) r.status = STAT_BADPOS;
        else list_model.insert(int'(pos) - 1, val);
      end
      OP_DELETE: begin
        if (n == 0) r.status = STAT_EMPTY;
        else if (pos == 0 || int'(pos) > n) r.status = STAT_BADPOS;
        else list_model.delete(int'(pos) - 1);
      end
      OP_FIND: begin
        for (i = 0; i < n; i++) begin
          if (list_model[i] == val && !r.found) begin
            r.found     = 1'b1;
            r.found_pos = POS_W'(i + 1);
          end
        end
      end
      default: ;
    endcase
    r.count = POS_W'(list_model.size());
    return r;
  endfunction

  // sample both channels mid-cycle: what is seen here is taken at the next rising edge
  always @(negedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: status=%0d found=%0d pos=%0d count=%0d",
                   $time, status, found, found_position, count);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status || found !== want.found ||
              found_position !== want.found_pos || count !== want.count) begin
            error_count++;
            $display("%0t: mismatch: expected status=%0d found=%0d pos=%0d count=%0d, %s",
                     $time, want.status, want.found, want.found_pos, want.count,
                     $sformatf("actual status=%0d found=%0d pos=%0d count=%0d",
                               status, found, found_position, count));
          end
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(apply_list_op(operation, value, position));
      // watchdog on cycles with no transaction on either side
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // result side stall: a long hold-off on request, otherwise random bursts
  initial begin : result_stall_gen
    int burst;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one transaction and return right after the edge that takes it
  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    int gap;
    bit taken;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= val;
    position  <= pos;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // one random operation; mix set by the growth and removal percentages
  task automatic send_random_item(input int grow_pct, input int drop_pct);
    int n;
    int roll;
    logic [OP_W-1:0] op;
    logic signed [VALUE_W-1:0] val;
    logic [POS_W-1:0] pos;
    n = list_model.size();
    roll = $urandom_range(0, 99);
    // small values repeat often so that find hits and duplicates show up
    if ($urandom_range(0, 1)) val = int'($urandom_range(0, 7)) - 4;
    else val = $urandom;
    pos = POS_W'($urandom_range(0, 63));
    if (roll < 2) begin
      op = OP_CLEAR;
    end else if (roll < 4) begin
      op = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
    end else if (roll < 4 + grow_pct) begin
      op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
      if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(1, n + 1));
    end else if (roll < 4 + grow_pct + drop_pct) begin
      op = OP_DELETE;
      if (n > 0 && $urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(1, n));
    end else begin
      op = OP_FIND;
      if (n > 0 && $urandom_range(0, 99) < 60) val = list_model[$urandom_range(0, n - 1)];
    end
    send_item(op, val, pos);
  endtask

  // rejects on an empty list, extreme values, both ends of the list, unused codes
  task automatic test_edge_cases();
    send_item(OP_DELETE, 0, 1);
    send_item(OP_DELETE, 0, 0);
    send_item(OP_FIND, 0, 0);
    send_item(OP_INSERT, 7, 0);
    send_item(OP_INSERT, 7, 2);
    send_item(OP_INSERT, VALUE_MAX, 1);
    send_item(OP_APPEND, VALUE_MIN, 0);
    send_item(OP_INSERT, -1, 1);
    send_item(OP_INSERT, 0, 4);
    send_item(OP_INSERT, 9, 63);
    send_item(OP_FIND, VALUE_MIN, 0);
    send_item(OP_APPEND, VALUE_MAX, 63);
    send_item(OP_FIND, VALUE_MAX, 0);
    send_item(OP_FIND, 12345, 0);
    send_item(OP_DELETE, 0, 0);
    send_item(OP_DELETE, 0, 6);
    send_item(OP_DELETE, 0, 1);
    send_item(OP_DELETE, 0, 4);
    send_item(OP_RESERVED_FIRST, VALUE_MAX, 1);
    send_item(OP_W'(OP_RESERVED_FIRST + 1), VALUE_MIN, 32);
    send_item(OP_RESERVED_LAST, -1, 63);
    send_item(OP_CLEAR, -1, 63);
    send_item(OP_FIND, VALUE_MAX, 0);
  endtask

  // fill to capacity, hit the full checks, then work at the top end
  task automatic test_capacity();
    logic signed [VALUE_W-1:0] last_val;
    send_item(OP_CLEAR, 0, 0);
    repeat (LIST_CAP) send_item(OP_APPEND, $urandom, POS_W'($urandom_range(0, 63)));
    last_val = list_model[LIST_CAP - 1];
    send_item(OP_APPEND, 1, 0);
    send_item(OP_INSERT, 1, 1);
    send_item(OP_INSERT, 1, 0);
    send_item(OP_FIND, last_val, 0);
    send_item(OP_DELETE, 0, POS_W'(LIST_CAP + 1));
    send_item(OP_DELETE, 0, POS_W'(LIST_CAP));
    send_item(OP_INSERT, VALUE_MIN, POS_W'(LIST_CAP));
    send_item(OP_DELETE, 0, 1);
  endtask

  // rounds of growth, churn and drain, with and without idling
  task automatic test_random_mix();
    int round_idx;
    for (round_idx = 0; round_idx < 3; round_idx++) begin
      idle_enable = (round_idx != 1);
      repeat (40) send_random_item(70, 10);
      repeat (40) send_random_item(35, 30);
      repeat (30) send_random_item(10, 65);
    end
    idle_enable = 1'b1;
  endtask

  // receiver holds off for a long time while the sender keeps offering
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (12) send_random_item(40, 30);
  endtask

  // last part of the run with no idling at all
  task automatic test_steady_stream();
    idle_enable = 1'b0;
    repeat (50) send_random_item(40, 30);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_edge_cases();
    test_capacity();
    test_random_mix();
    test_backpressure();
    test_steady_stream();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * LIST_CAP) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pal_pkg.sv
hdl/pal_cell.sv
hdl/positional_array_list_top.sv
tb/positional_array_list_top_tb.sv
